// File: design/kpsd_pkg.sv
// ----------------------------------------------------------------------------
// kpsd_pkg
// shared types and constants for the keypad scan and debounce unit
// ----------------------------------------------------------------------------
package kpsd_pkg;

  localparam int ROW_COUNT    = 6;
  localparam int COLUMN_COUNT = 5;
  localparam int CODE_W       = 8;
  localparam int TIME_W       = 8;

  // key event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DOWN = 2'd1;
  localparam logic [1:0] EV_UP   = 2'd2;

  typedef logic [COLUMN_COUNT-1:0] columns_t;

  typedef struct packed {
    columns_t          row0_columns;
    columns_t          row1_columns;
    columns_t          row2_columns;
    columns_t          row3_columns;
    columns_t          row4_columns;
    columns_t          direct_columns;
    logic [TIME_W-1:0] coarse_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0] key_event;
    logic [6:0] key_code;
  } out_item_t;

  // classified poll passed from front to back
  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] now;
  } scan_t;

endpackage

// File: design/kpsd_front.sv
// ----------------------------------------------------------------------------
// kpsd_front
// scan encoder: finds the detecting row and builds its key code
// ----------------------------------------------------------------------------
module kpsd_front
  import kpsd_pkg::*;
(
  input  in_item_t item,
  output scan_t    scan
);

  localparam int ROW_IDX_W = $clog2(ROW_COUNT);
  localparam int COL_IDX_W = $clog2(COLUMN_COUNT);

  columns_t rows [ROW_COUNT];

  assign rows[0] = item.row0_columns;
  assign rows[1] = item.row1_columns;
  assign rows[2] = item.row2_columns;
  assign rows[3] = item.row3_columns;
  assign rows[4] = item.row4_columns;
  assign rows[5] = item.direct_columns;

  always_comb begin
    columns_t   own;
    columns_t   drive;
    columns_t   t;
    logic [3:0] col;
    scan.found = 1'b0;
    scan.code  = '0;
    scan.now   = item.coarse_time;
    // last detecting row wins
    for (int r = 0; r < ROW_COUNT; r++) begin
      // own column bit of a driven row, none for the direct row
      own   = columns_t'(1) << r;
      drive = ~own;
      t     = rows[ROW_IDX_W'(r)] | own;
      col = 4'(COLUMN_COUNT);
      for (int c = COLUMN_COUNT - 1; c >= 0; c--) begin
        if (!t[COL_IDX_W'(c)]) col = 4'(c);
      end
      if (rows[ROW_IDX_W'(r)] != drive) begin
        scan.found = 1'b1;
        scan.code  = {4'(r), col};
      end
    end
  end

endmodule

// File: design/kpsd_queue.sv
// ----------------------------------------------------------------------------
// kpsd_queue
// two-entry queue between scan front and debounce back
// ----------------------------------------------------------------------------
module kpsd_queue
  import kpsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  scan_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output logic  valid,
  output scan_t rd_data
);

  localparam int DEPTH = 2;

  scan_t       mem_r [DEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_wr, do_rd;

  assign full    = (count_r == 2'(DEPTH));
  assign valid   = (count_r != 2'd0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// File: design/kpsd_back.sv
// ----------------------------------------------------------------------------
// kpsd_back
// debounce state machine with a registered result slot
// ----------------------------------------------------------------------------
module kpsd_back
  import kpsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      scan_valid,
  input  scan_t     scan,
  output logic      scan_take,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_WAIT    = 2'd1;
  localparam logic [1:0] ST_CONFIRM = 2'd2;
  localparam logic [1:0] ST_HOLD    = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CODE_W-1:0] held_r, held_nxt;
  logic [CODE_W-1:0] latest_r, latest_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic [1:0]        event_nxt;
  logic [CODE_W-1:0] latest_upd;

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;
  // slot frees when empty or popped this cycle
  assign scan_take = scan_valid && (!out_valid_r || out_pop);

  always_comb begin
    latest_upd = scan.found ? scan.code : latest_r;
    state_nxt  = state_r;
    held_nxt   = held_r;
    latest_nxt = latest_upd;
    start_nxt  = start_r;
    event_nxt  = EV_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (scan.found) begin
          start_nxt  = scan.now;
          held_nxt   = latest_upd;
          latest_nxt = ~latest_upd;
          state_nxt  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (scan.now != start_r) state_nxt = ST_CONFIRM;
      end
      ST_CONFIRM: begin
        if (latest_upd == held_r) begin
          latest_nxt = ~latest_upd;
          state_nxt  = ST_HOLD;
          event_nxt  = EV_DOWN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (latest_upd == held_r) begin
          latest_nxt = ~latest_upd;
          event_nxt  = EV_DOWN;
        end else begin
          state_nxt = ST_IDLE;
          event_nxt = EV_UP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      latest_r    <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (scan_take) begin
        state_r  <= state_nxt;
        held_r   <= held_nxt;
        latest_r <= latest_nxt;
        start_r  <= start_nxt;
      end
      if (scan_take) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_take) begin
      out_data_r.key_event <= event_nxt;
      out_data_r.key_code  <= held_nxt[6:0];
    end
  end

endmodule

// File: design/matrix_keypad_scan_debounce_unit.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce_unit
// keypad poll encoder and debounce state machine, queue in, queue out
// ----------------------------------------------------------------------------
// usage
//   input side: each poll request carries the five driven-row column readings,
//   the direct-key readings and an 8-bit coarse time; it is taken at a clock
//   edge with in_push high and in_full low
//   output side: exactly one result per poll (key_event, key_code); the oldest
//   result sits on out_data while out_empty is low and leaves on out_pop
//   path: a taken poll is written to the middle queue and from there to the
//   result register once the result slot is free; out_empty falls when the
//   result register is written
//   throughput: one poll per cycle while the result slot is free, set by the
//   debounce update in the back stage
//   stall: if out_pop stays low the result slot holds, the back stage stops,
//   the two-entry middle queue fills and in_full rises after two more polls
//   reset: rst_n low (synchronous) empties both queues and returns the
//   debounce machine to idle with held code, latest scan and start time zero
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce_unit
  import kpsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  // classified poll from the encoder
  scan_t front_scan;
  // head of the middle queue
  scan_t q_scan;
  logic  q_valid;
  logic  q_take;

  // front: row scan and key code encode
  kpsd_front u_front (
    .item (in_data),
    .scan (front_scan)
  );

  // middle queue decouples encoder from debounce machine
  kpsd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (front_scan),
    .full    (in_full),
    .rd_en   (q_take),
    .valid   (q_valid),
    .rd_data (q_scan)
  );

  // back: debounce state machine and result register
  kpsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_valid (q_valid),
    .scan       (q_scan),
    .scan_take  (q_take),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule
